FILE: hw/rtl/fsd_pkg.sv
// shared types and constants for the fnv-1a string deduplicator
// no dependencies
`default_nettype none

package fsd_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int INDEX_W     = 10;
    localparam int HASH_W      = 32;
    localparam int BYTE_W      = 8;

    localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;
    localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_CMP  = 4'b0100,
        ST_EMIT = 4'b1000
    } search_state_t;

    typedef struct packed {
        logic update;
        logic clear;
    } hash_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/fsd_hash.sv
// running fnv-1a hash register with one 32x32 multiplier
// depends on fsd_pkg
`default_nettype none

module fsd_hash
    import fsd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire hash_ctrl_t        ctrl,
    input  wire logic [BYTE_W-1:0] data_byte,
    output logic [HASH_W-1:0]      hash
);

    logic [HASH_W-1:0] hash_reg;
    logic [HASH_W-1:0] hash_next;
    logic [HASH_W-1:0] mixed;

    assign mixed = hash_reg ^ {{(HASH_W-BYTE_W){1'b0}}, data_byte};

    always_comb
    begin
        hash_next = hash_reg;
        if (ctrl.clear)
        begin
            hash_next = FNV_BASIS;
        end
        else if (ctrl.update)
        begin
            hash_next = HASH_W'(mixed * FNV_PRIME);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= FNV_BASIS;
        end
        else
        begin
            hash_reg <= hash_next;
        end
    end

    assign hash = hash_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/fsd_search.sv
// hash store, sequential table walk with one comparator, result register
// depends on fsd_pkg
`default_nettype none

module fsd_search
    import fsd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [HASH_W-1:0] key,
    output logic                   busy,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   out_dup,
    output logic                   out_full,
    output logic [HASH_W-1:0]      out_hash,
    output logic [INDEX_W-1:0]     out_index
);

    logic [HASH_W-1:0] mem [TABLE_DEPTH];

    search_state_t     state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              found_reg, found_next;
    logic              out_valid_reg, out_valid_next;
    logic [HASH_W-1:0] key_reg;
    logic [HASH_W-1:0] rd_data_reg;
    logic              out_dup_reg, out_full_reg;
    logic [HASH_W-1:0] out_hash_reg;
    logic [INDEX_W-1:0] out_index_reg;
    logic              load;
    logic              wr_en;
    logic              has_room;

    assign has_room = (count_reg < DEPTH_CNT);
    assign load     = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);
    assign wr_en    = load && !found_reg && has_room;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        found_next = found_reg;
        count_next = count_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    idx_next   = '0;
                    found_next = 1'b0;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (idx_reg == count_reg)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (rd_data_reg == key_reg)
                begin
                    found_next = 1'b1;
                    state_next = ST_EMIT;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_EMIT:
            begin
                if (load)
                begin
                    if (wr_en)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && state_reg == ST_IDLE)
        begin
            key_reg <= key;
        end
        if (load)
        begin
            out_dup_reg  <= found_reg;
            out_full_reg <= !found_reg && !has_room;
            out_hash_reg <= key_reg;
            if (found_reg)
            begin
                out_index_reg <= idx_reg[INDEX_W-1:0];
            end
            else if (has_room)
            begin
                out_index_reg <= count_reg[INDEX_W-1:0];
            end
            else
            begin
                out_index_reg <= '0;
            end
        end
    end

    // table store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[ADDR_W-1:0]] <= key_reg;
        end
        rd_data_reg <= mem[idx_reg[ADDR_W-1:0]];
    end

    assign busy      = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_dup   = out_dup_reg;
    assign out_full  = out_full_reg;
    assign out_hash  = out_hash_reg;
    assign out_index = out_index_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("entry count beyond table depth");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ || state_reg == ST_CMP) |-> idx_reg <= count_reg)
        else $error("walk index past stored entries");

    a_cmp_not_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CMP |-> idx_reg < count_reg)
        else $error("compare issued past stored entries");

    a_dup_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (load && found_reg) |=> $stable(count_reg))
        else $error("duplicate changed entry count");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_dup_reg && out_full_reg))
        else $error("duplicate and full flagged together");

endmodule

`default_nettype wire

FILE: hw/rtl/fnv1a_string_dedup.sv
// top level of the fnv-1a string deduplicator: stream ports, hash and search
// depends on fsd_pkg, fsd_hash, fsd_search
// data beat: taken whenever tready is high, next beat may follow in the next cycle
// end beat: stored entries walked in order up to the first match, one table read
// and one compare per entry; result registered after the walk, later while the previous
// result is held; tready low until then. reset: hash to offset basis, count to zero
`default_nettype none

module fnv1a_string_dedup
    import fsd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // data_byte[7:0]
    input  wire logic        s_axis_tlast,   // end_of_string
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // hash_value[31:0], entry_index[41:32], zero
    output logic [1:0]       m_axis_tuser    // is_duplicate[0], store_full[1]
);

    hash_ctrl_t         hctrl;
    logic [HASH_W-1:0]  hash;
    logic               busy;
    logic               beat;
    logic               out_dup;
    logic               out_full;
    logic [HASH_W-1:0]  out_hash;
    logic [INDEX_W-1:0] out_index;

    assign s_axis_tready = !busy;
    assign beat          = s_axis_tvalid && s_axis_tready;
    assign hctrl.update  = beat && !s_axis_tlast;
    assign hctrl.clear   = beat && s_axis_tlast;

    fsd_hash u_hash (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (hctrl),
        .data_byte (s_axis_tdata),
        .hash      (hash)
    );

    fsd_search u_search (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (hctrl.clear),
        .key       (hash),
        .busy      (busy),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_dup   (out_dup),
        .out_full  (out_full),
        .out_hash  (out_hash),
        .out_index (out_index)
    );

    assign m_axis_tdata = {6'b0, out_index, out_hash};
    assign m_axis_tuser = {out_full, out_dup};

endmodule

`default_nettype wire

FILE: verif/fnv1a_string_dedup_tb.sv
// testbench for fnv1a_string_dedup: byte strings in, dedup verdicts out, checked
// against an in-bench fnv-1a hash and hash-set predictor; depends on fsd_pkg
`timescale 1ns / 100ps

module fnv1a_string_dedup_tb;
    import fsd_pkg::*;

    localparam int CYCLE_LIMIT     = 12_000_000;
    localparam int ITEMS_PER_PHASE = 550;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } byte_beat_t;

    typedef struct packed {
        logic        dup;
        logic [31:0] hash;
        logic [9:0]  index;
        logic        full;
    } dedup_verdict_t;

    typedef struct {
        int          len;
        logic [95:0] bytes;
    } text_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    byte_beat_t     pending_beats[$];
    dedup_verdict_t expected_verdicts[$];
    text_t          sent_texts[$];

    logic [31:0] string_hash;
    logic [31:0] seen_table [TABLE_DEPTH];
    int          stored_count = 0;
    int          queued_items = 0;

    int   send_idle_pct = 24;
    int   recv_idle_pct = 45;
    logic in_fire = 1'b0;
    int   error_count = 0;
    int   cycle_count = 0;

    fnv1a_string_dedup DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
        error_count++;
    endtask

    task automatic hash_and_lookup(input logic [7:0] b, input logic last);
        logic [31:0]    h;
        int             slot;
        dedup_verdict_t v;
        if (!last)
        begin
            string_hash = (string_hash ^ {24'h0, b}) * FNV_PRIME;
        end
        else
        begin
            h = string_hash;
            string_hash = FNV_BASIS;
            slot = -1;
            for (int i = 0; i < stored_count; i++)
                if (slot < 0 && seen_table[i] == h)
                    slot = i;
            v.dup  = 1'b0;
            v.full = 1'b0;
            v.hash = h;
            if (slot >= 0)
            begin
                v.dup   = 1'b1;
                v.index = slot[9:0];
            end
            else if (stored_count < TABLE_DEPTH)
            begin
                seen_table[stored_count] = h;
                v.index = stored_count[9:0];
                stored_count++;
            end
            else
            begin
                v.full  = 1'b1;
                v.index = 10'd0;
            end
            expected_verdicts.push_back(v);
        end
    endtask

    task automatic check_verdict;
        dedup_verdict_t v;
        if (expected_verdicts.size() == 0)
        begin
            report_mismatch("unexpected result, hash", m_axis_tdata[31:0], 32'h0);
        end
        else
        begin
            v = expected_verdicts.pop_front();
            if (m_axis_tdata[31:0] !== v.hash)
                report_mismatch("hash_value", m_axis_tdata[31:0], v.hash);
            if (m_axis_tdata[41:32] !== v.index)
                report_mismatch("entry_index", {22'h0, m_axis_tdata[41:32]}, {22'h0, v.index});
            if (m_axis_tdata[47:42] !== 6'h0)
                report_mismatch("tdata padding", {26'h0, m_axis_tdata[47:42]}, 32'h0);
            if (m_axis_tuser[0] !== v.dup)
                report_mismatch("is_duplicate", {31'h0, m_axis_tuser[0]}, {31'h0, v.dup});
            if (m_axis_tuser[1] !== v.full)
                report_mismatch("store_full", {31'h0, m_axis_tuser[1]}, {31'h0, v.full});
        end
    endtask

    // sample both handshakes at the rising edge
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_fire <= 1'b0;
            string_hash = FNV_BASIS;
        end
        else
        begin
            in_fire <= s_axis_tvalid && s_axis_tready;
            if (m_axis_tvalid && m_axis_tready)
                check_verdict();
            if (s_axis_tvalid && s_axis_tready)
                hash_and_lookup(s_axis_tdata, s_axis_tlast);
        end
    end

    // driver: hold a beat until taken, then maybe idle
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_fire)
                void'(pending_beats.pop_front());
            if (s_axis_tvalid && !in_fire)
            begin
                s_axis_tvalid <= 1'b1;
            end
            else if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pending_beats[0].data;
                s_axis_tlast  <= pending_beats[0].last;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("fnv1a_string_dedup verification failed");
            $finish;
        end
    end

    task automatic queue_text(input text_t t);
        byte_beat_t b;
        for (int i = 0; i < t.len; i++)
        begin
            b.data = t.bytes[8*i +: 8];
            b.last = 1'b0;
            pending_beats.push_back(b);
        end
        // byte on the end beat is ignored, so randomize it
        b.data = 8'($urandom_range(255));
        b.last = 1'b1;
        pending_beats.push_back(b);
        queued_items += t.len + 1;
    endtask

    task automatic queue_random_string;
        text_t t;
        int    kind;
        int    sel;
        if ($urandom_range(99) < 15 && sent_texts.size() > 0)
        begin
            t = sent_texts[$urandom_range(sent_texts.size() - 1)];
        end
        else
        begin
            kind = $urandom_range(99);
            if (kind < 2)
                t.len = 0;
            else if (kind < 10)
                t.len = 1;
            else if (kind < 88)
                t.len = $urandom_range(3, 2);
            else
                t.len = $urandom_range(12, 4);
            t.bytes = '0;
            for (int i = 0; i < t.len; i++)
            begin
                sel = $urandom_range(15);
                if (sel == 0)
                    t.bytes[8*i +: 8] = 8'h00;
                else if (sel == 1)
                    t.bytes[8*i +: 8] = 8'hFF;
                else
                    t.bytes[8*i +: 8] = 8'($urandom_range(255));
            end
            sent_texts.push_back(t);
        end
        queue_text(t);
    endtask

    task automatic wait_drained;
        while (pending_beats.size() != 0 || expected_verdicts.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        text_t t;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // empty string, then again as a duplicate
        t.len = 0;  t.bytes = '0;
        queue_text(t);
        queue_text(t);
        // zero byte, all-ones byte, two zero bytes, then a repeated all-ones byte and multi-byte strings with a repeat
        t.len = 1;  t.bytes = 96'h00;
        queue_text(t);
        t.len = 1;  t.bytes = 96'hFF;
        queue_text(t);
        t.len = 2;  t.bytes = 96'h0000;
        queue_text(t);
        t.len = 1;  t.bytes = 96'hFF;
        queue_text(t);
        t.len = 2;  t.bytes = 96'hAA55;
        queue_text(t);
        t.len = 3;  t.bytes = 96'h01FF80;
        queue_text(t);
        t.len = 2;  t.bytes = 96'hAA55;
        queue_text(t);
        wait_drained();

        // random strings in three phases of sender and receiver idling, the last with no idling
        for (int phase = 0; phase < 3; phase++)
        begin
            if (phase == 0)
            begin
                send_idle_pct = 24;
                recv_idle_pct = 45;
            end
            else if (phase == 1)
            begin
                send_idle_pct = 45;
                recv_idle_pct = 24;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            while (queued_items < (phase + 1) * ITEMS_PER_PHASE)
                queue_random_string();
            wait_drained();
        end

        repeat (2 * TABLE_DEPTH + 16) @(posedge clk);
        if (error_count == 0)
            $display("fnv1a_string_dedup verification clean");
        else
            $display("fnv1a_string_dedup verification failed");
        $finish;
    end

endmodule

FILE: fnv1a_string_dedup.f
hw/rtl/fsd_pkg.sv
hw/rtl/fsd_hash.sv
hw/rtl/fsd_search.sv
hw/rtl/fnv1a_string_dedup.sv
verif/fnv1a_string_dedup_tb.sv
